### rtl/core/hfwrl_pkg.sv
`timescale 1ns / 1ps

package hfwrl_pkg;

    localparam int CHAR_W        = 8;
    localparam int TIME_W        = 32;
    localparam int COUNT_W       = 16;
    localparam int HASH_W        = 32;
    localparam int BUCKET_W      = 10;
    localparam int TABLE_ENTRIES = 1024;

    localparam logic [HASH_W-1:0]  HASH_SEED   = 32'd5381;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd100;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    // Control from the sequencer to the character intake
    typedef struct packed {
        logic take;
        logic restart;
    } t_intake_ctl;

endpackage

### rtl/core/hfwrl_if.sv
`timescale 1ns / 1ps

interface hfwrl_req_if;
    logic                          valid;
    logic                          ready;
    logic [hfwrl_pkg::CHAR_W-1:0]  key_char;
    logic                          last_char;
    logic [hfwrl_pkg::TIME_W-1:0]  now_seconds;

    modport source (output valid, output key_char, output last_char, output now_seconds,
                    input ready);
    modport sink   (input valid, input key_char, input last_char, input now_seconds,
                    output ready);
endinterface

interface hfwrl_resp_if;
    logic                           valid;
    logic                           ready;
    logic                           allowed;
    logic [hfwrl_pkg::COUNT_W-1:0]  window_count;
    logic [hfwrl_pkg::BUCKET_W-1:0] bucket;

    modport source (output valid, output allowed, output window_count, output bucket,
                    input ready);
    modport sink   (input valid, input allowed, input window_count, input bucket,
                    output ready);
endinterface

### rtl/core/hfwrl_ram.sv
`timescale 1ns / 1ps

module hfwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/hfwrl_intake.sv
`timescale 1ns / 1ps

module hfwrl_intake #(
    parameter int KEY_CHARS = 63
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hfwrl_pkg::t_intake_ctl         i_ctl,
    input  logic [hfwrl_pkg::CHAR_W-1:0]   i_char,
    output logic [hfwrl_pkg::BUCKET_W-1:0] o_bucket,
    output logic [$clog2(KEY_CHARS+2)-1:0] o_len,
    output logic                           o_key_we,
    output logic [$clog2(KEY_CHARS)-1:0]   o_key_waddr
);

    localparam int LEN_W = $clog2(KEY_CHARS + 2);
    localparam int IDX_W = $clog2(KEY_CHARS);

    logic [hfwrl_pkg::HASH_W-1:0] r_hash, n_hash;
    logic [LEN_W-1:0]             r_len, n_len;

    always_comb begin
        n_hash = r_hash;
        n_len  = r_len;
        if (i_ctl.restart) begin
            n_hash = hfwrl_pkg::HASH_SEED;
            n_len  = '0;
        end else if (i_ctl.take) begin
            // h * 33 + c as shift and add
            n_hash = {r_hash[hfwrl_pkg::HASH_W-6:0], 5'b0} + r_hash
                   + {{(hfwrl_pkg::HASH_W - hfwrl_pkg::CHAR_W){1'b0}}, i_char};
            // saturate one past the key size to mark an over-long key
            if (r_len <= LEN_W'(KEY_CHARS)) begin
                n_len = r_len + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= hfwrl_pkg::HASH_SEED;
            r_len  <= '0;
        end else begin
            r_hash <= n_hash;
            r_len  <= n_len;
        end
    end

    assign o_bucket    = r_hash[hfwrl_pkg::BUCKET_W-1:0];
    assign o_len       = r_len;
    assign o_key_we    = i_ctl.take && (r_len < LEN_W'(KEY_CHARS));
    assign o_key_waddr = r_len[IDX_W-1:0];

endmodule

### rtl/core/hashed_fixed_window_rate_limiter.sv
`timescale 1ns / 1ps
// Per-client request admission with a fixed one-second window.
// i_req carries the client address one character per transaction; last_char
// marks the final character and now_seconds is sampled with it. Every final
// character yields one transaction on o_resp: allowed, the entry's count after
// the decision and the selected bucket. Other characters yield nothing.
// Non-final characters are taken back to back. A final character is accepted,
// then its kept characters, the address length capped at KEY_CHARS, are
// compared and copied serially through the single read port of the stored key
// RAM, and then the entry is decided and written back once the output is free.
// i_req.ready is low from a final character until its decision is made.
// Reset starts a clearing pass over the entry table, one entry a cycle, with
// i_req.ready low; configuration writes are taken throughout.
// The result sits in an output register: the next address streams in while it
// waits, and a stalled receiver only holds the next decision back.
// i_cfg_we/i_cfg_wdata write the per-window request limit (reset 100).
module hashed_fixed_window_rate_limiter #(
    parameter int KEY_CHARS = 63
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hfwrl_pkg::COUNT_W-1:0] i_cfg_wdata,
    hfwrl_req_if.sink                     i_req,
    hfwrl_resp_if.source                  o_resp
);

    localparam int LEN_W     = $clog2(KEY_CHARS + 2);
    localparam int IDX_W     = $clog2(KEY_CHARS);
    localparam int SLEN_W    = $clog2(KEY_CHARS + 1);
    localparam int TIME_W    = hfwrl_pkg::TIME_W;
    localparam int COUNT_W   = hfwrl_pkg::COUNT_W;
    localparam int BUCKET_W  = hfwrl_pkg::BUCKET_W;
    localparam int ENTRY_W   = SLEN_W + TIME_W + COUNT_W;
    localparam int KEY_DEPTH = hfwrl_pkg::TABLE_ENTRIES * (2 ** IDX_W);

    hfwrl_pkg::t_state      r_state, n_state;
    hfwrl_pkg::t_intake_ctl w_ctl;

    logic [BUCKET_W-1:0] r_clr, n_clr;
    logic [LEN_W-1:0]    r_idx, n_idx;
    logic                r_eq, n_eq;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [COUNT_W-1:0]  r_limit;

    logic                r_out_valid, n_out_valid;
    logic                r_allowed, n_allowed;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [BUCKET_W-1:0] r_bucket, n_bucket;

    logic [BUCKET_W-1:0] w_bucket;
    logic [LEN_W-1:0]    w_len;
    logic                w_in_we;
    logic [IDX_W-1:0]    w_in_waddr;
    logic [SLEN_W-1:0]   w_keep;
    logic                w_take;

    // incoming key RAM
    logic                     w_in_re;
    logic [hfwrl_pkg::CHAR_W-1:0] w_in_char;

    // stored key RAM
    logic                     w_st_we, w_st_re;
    logic [IDX_W-1:0]         w_st_widx;
    logic [hfwrl_pkg::CHAR_W-1:0] w_st_char;

    // entry RAM: {length, window start, count}
    logic                w_ent_we, w_ent_re;
    logic [BUCKET_W-1:0] w_ent_waddr;
    logic [ENTRY_W-1:0]  w_ent_wdata, w_ent_rdata;

    logic [SLEN_W-1:0]   w_st_len;
    logic [TIME_W-1:0]   w_st_start, w_diff;
    logic [COUNT_W-1:0]  w_st_cnt, w_new_cnt;
    logic                w_match, w_within, w_hit, w_deny, w_slot_free;
    logic [LEN_W-1:0]    w_prev;

    assign w_take = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == hfwrl_pkg::S_IDLE);

    // Over-long keys keep only the first KEY_CHARS characters
    assign w_keep = (w_len > LEN_W'(KEY_CHARS)) ? SLEN_W'(KEY_CHARS) : w_len[SLEN_W-1:0];

    assign {w_st_len, w_st_start, w_st_cnt} = w_ent_rdata;

    assign w_diff      = r_now - w_st_start;
    // a clock running backwards still counts as inside the window
    assign w_within    = (w_diff == '0) || w_diff[TIME_W-1];
    assign w_match     = r_eq && (w_len == LEN_W'(w_st_len));
    assign w_hit       = w_match && w_within;
    assign w_deny      = w_hit && (w_st_cnt >= r_limit);
    assign w_new_cnt   = w_deny ? w_st_cnt :
                         (w_hit ? w_st_cnt + COUNT_W'(1) : COUNT_W'(1));
    assign w_slot_free = !r_out_valid || o_resp.ready;
    assign w_prev      = r_idx - LEN_W'(1);

    hfwrl_intake #(.KEY_CHARS(KEY_CHARS)) u_intake (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_char      (i_req.key_char),
        .o_bucket    (w_bucket),
        .o_len       (w_len),
        .o_key_we    (w_in_we),
        .o_key_waddr (w_in_waddr)
    );

    hfwrl_ram #(.WIDTH(hfwrl_pkg::CHAR_W), .DEPTH(2 ** IDX_W)) u_in_key (
        .i_clk   (i_clk),
        .i_we    (w_in_we),
        .i_waddr (w_in_waddr),
        .i_wdata (i_req.key_char),
        .i_re    (w_in_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_in_char)
    );

    hfwrl_ram #(.WIDTH(hfwrl_pkg::CHAR_W), .DEPTH(KEY_DEPTH)) u_st_key (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr ({w_bucket, w_st_widx}),
        .i_wdata (w_in_char),
        .i_re    (w_st_re),
        .i_raddr ({w_bucket, r_idx[IDX_W-1:0]}),
        .o_rdata (w_st_char)
    );

    hfwrl_ram #(.WIDTH(ENTRY_W), .DEPTH(hfwrl_pkg::TABLE_ENTRIES)) u_entry (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_re    (w_ent_re),
        .i_raddr (w_bucket),
        .o_rdata (w_ent_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_eq        = r_eq;
        n_now       = r_now;
        n_allowed   = r_allowed;
        n_count     = r_count;
        n_bucket    = r_bucket;
        n_out_valid = r_out_valid && !o_resp.ready;

        w_ctl.take    = w_take;
        w_ctl.restart = 1'b0;

        w_in_re     = 1'b0;
        w_st_re     = 1'b0;
        w_st_we     = 1'b0;
        w_st_widx   = w_prev[IDX_W-1:0];
        w_ent_re    = 1'b0;
        w_ent_we    = 1'b0;
        w_ent_waddr = w_bucket;
        w_ent_wdata = {w_keep, r_now, COUNT_W'(1)};

        case (r_state)
            hfwrl_pkg::S_CLEAR: begin
                // zero one entry a cycle: empty key, no window
                w_ent_we    = 1'b1;
                w_ent_waddr = r_clr;
                w_ent_wdata = '0;
                n_clr       = r_clr + BUCKET_W'(1);
                if (r_clr == BUCKET_W'(hfwrl_pkg::TABLE_ENTRIES - 1)) begin
                    n_state = hfwrl_pkg::S_IDLE;
                end
            end
            hfwrl_pkg::S_IDLE: begin
                if (w_take && i_req.last_char) begin
                    n_now   = i_req.now_seconds;
                    n_idx   = '0;
                    n_eq    = 1'b1;
                    n_state = hfwrl_pkg::S_SCAN;
                end
            end
            hfwrl_pkg::S_SCAN: begin
                // read character idx, compare and copy character idx - 1
                w_ent_re = (r_idx == '0);
                if (r_idx < LEN_W'(w_keep)) begin
                    w_in_re = 1'b1;
                    w_st_re = 1'b1;
                end
                if (r_idx != '0) begin
                    n_eq    = r_eq && (w_in_char == w_st_char);
                    w_st_we = 1'b1;
                end
                if (r_idx == LEN_W'(w_keep)) begin
                    n_state = hfwrl_pkg::S_DECIDE;
                end else begin
                    n_idx = r_idx + LEN_W'(1);
                end
            end
            hfwrl_pkg::S_DECIDE: begin
                // hold until the previous result has been taken
                if (w_slot_free) begin
                    w_ent_we = 1'b1;
                    if (w_hit) begin
                        w_ent_wdata = {w_st_len, w_st_start, w_new_cnt};
                    end
                    n_out_valid   = 1'b1;
                    n_allowed     = !w_deny;
                    n_count       = w_new_cnt;
                    n_bucket      = w_bucket;
                    w_ctl.restart = 1'b1;
                    n_state       = hfwrl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hfwrl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hfwrl_pkg::S_CLEAR;
            r_clr       <= '0;
            r_idx       <= '0;
            r_eq        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_idx       <= n_idx;
            r_eq        <= n_eq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_allowed <= n_allowed;
        r_count   <= n_count;
        r_bucket  <= n_bucket;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= hfwrl_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    assign o_resp.valid        = r_out_valid;
    assign o_resp.allowed      = r_allowed;
    assign o_resp.window_count = r_count;
    assign o_resp.bucket       = r_bucket;

endmodule

### dv/hashed_fixed_window_rate_limiter_tb.sv
`timescale 1ns / 1ps

module hashed_fixed_window_rate_limiter_tb;

    localparam int CHAR_W        = hfwrl_pkg::CHAR_W;
    localparam int TIME_W        = hfwrl_pkg::TIME_W;
    localparam int COUNT_W       = hfwrl_pkg::COUNT_W;
    localparam int HASH_W        = hfwrl_pkg::HASH_W;
    localparam int BUCKET_W      = hfwrl_pkg::BUCKET_W;
    localparam int TABLE_ENTRIES = hfwrl_pkg::TABLE_ENTRIES;

    localparam int KEY_CHARS       = 63;
    localparam int CLIENTS         = 12;
    // Long enough for the slowest decision, a key of KEY_CHARS characters, with margin on top.
    localparam int SETTLE_CYCLES   = KEY_CHARS + 16;
    localparam int HOLD_OFF_CYCLES = 400;
    // Longest legitimate quiet spell is the clearing pass after reset.
    localparam int WATCHDOG_LIMIT  = 5000;

    typedef logic [CHAR_W-1:0] t_key [$];

    typedef struct packed {
        logic [CHAR_W-1:0] key_char;
        logic              last_char;
        logic [TIME_W-1:0] now_seconds;
    } t_char_txn;

    typedef struct packed {
        logic               allowed;
        logic [COUNT_W-1:0] window_count;
        logic [BUCKET_W-1:0] bucket;
    } t_verdict;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_wdata;

    hfwrl_req_if  req_if ();
    hfwrl_resp_if resp_if ();

    hashed_fixed_window_rate_limiter #(
        .KEY_CHARS(KEY_CHARS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_resp     (resp_if)
    );

    // Admission predictor state: hash and key being assembled, plus a full
    // copy of the entry table and the current limit.
    logic [COUNT_W-1:0] rate_limit;
    logic [HASH_W-1:0]  djb2_acc;
    int unsigned        key_len;
    logic [CHAR_W-1:0]  key_buf [KEY_CHARS];
    logic [CHAR_W-1:0]  entry_key [TABLE_ENTRIES][KEY_CHARS];
    int unsigned        entry_len [TABLE_ENTRIES];
    logic [TIME_W-1:0]  entry_start [TABLE_ENTRIES];
    logic [COUNT_W-1:0] entry_count [TABLE_ENTRIES];
    t_verdict           verdicts_due [$];

    // Stimulus plumbing
    t_char_txn   char_stream [$];
    t_char_txn   next_char;
    t_key        client_key [CLIENTS];
    logic [TIME_W-1:0] wall_clock;
    int unsigned chars_outstanding;
    int unsigned chars_queued;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_off_req;
    int unsigned hold_cycles_left;
    bit          char_taken;

    // Bookkeeping
    int unsigned errors;
    int unsigned decisions;
    int unsigned admitted;
    int unsigned denied;
    int unsigned limit_settings;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fold one accepted character into the predictor; on the final character
    // look up the entry, decide and queue the verdict the block must produce.
    task automatic admit_char(input t_char_txn t);
        logic [BUCKET_W-1:0] b;
        logic [TIME_W-1:0]   diff;
        bit                  same_key;
        bit                  in_window;
        int unsigned         keep;
        t_verdict            v;
        djb2_acc = djb2_acc * 33 + t.key_char;
        if (key_len < KEY_CHARS)
            key_buf[key_len] = t.key_char;
        if (key_len <= KEY_CHARS)
            key_len++;
        if (t.last_char) begin
            b         = djb2_acc[BUCKET_W-1:0];
            diff      = t.now_seconds - entry_start[b];
            // A stale (negative) timestamp still counts as the same window
            in_window = (diff == '0) || diff[TIME_W-1];
            // Stored lengths never exceed KEY_CHARS, so an over-long key misses
            same_key  = (key_len == entry_len[b]);
            for (int i = 0; i < KEY_CHARS; i++)
                if (i < key_len && entry_key[b][i] != key_buf[i])
                    same_key = 1'b0;
            if (same_key && in_window) begin
                if (entry_count[b] >= rate_limit) begin
                    v.allowed = 1'b0;
                end else begin
                    entry_count[b] = entry_count[b] + 1'b1;
                    v.allowed      = 1'b1;
                end
            end else begin
                keep = (key_len > KEY_CHARS) ? KEY_CHARS : key_len;
                for (int i = 0; i < KEY_CHARS; i++)
                    if (i < keep)
                        entry_key[b][i] = key_buf[i];
                entry_len[b]   = keep;
                entry_start[b] = t.now_seconds;
                entry_count[b] = COUNT_W'(1);
                v.allowed      = 1'b1;
            end
            v.window_count = entry_count[b];
            v.bucket       = b;
            verdicts_due.push_back(v);
            djb2_acc = hfwrl_pkg::HASH_SEED;
            key_len  = 0;
        end
    endtask

    function automatic t_key text_key(input string s);
        t_key k;
        for (int i = 0; i < s.len(); i++)
            k.push_back(s[i]);
        return k;
    endfunction

    function automatic t_key random_key(input int unsigned len);
        t_key k;
        for (int i = 0; i < len; i++)
            k.push_back(CHAR_W'($urandom_range(1, 255)));
        return k;
    endfunction

    // Break one address into character transactions; the timestamp only
    // matters on the final one, so randomise it elsewhere.
    task automatic queue_request(input t_key key, input logic [TIME_W-1:0] stamp);
        t_char_txn t;
        foreach (key[i]) begin
            t.key_char    = key[i];
            t.last_char   = (i == key.size() - 1);
            t.now_seconds = t.last_char ? stamp : TIME_W'($urandom);
            char_stream.push_back(t);
            chars_outstanding++;
            chars_queued++;
        end
    endtask

    // Fresh client pool: one key of exactly KEY_CHARS characters, one just
    // over it (stored truncated), a one-character key and a mix of others.
    task automatic new_clients();
        for (int c = 0; c < CLIENTS; c++) begin
            if (c == 0)
                client_key[c] = random_key(KEY_CHARS);
            else if (c == 1)
                client_key[c] = random_key(KEY_CHARS + 1);
            else if (c == 2)
                client_key[c] = random_key(1);
            else if ($urandom_range(9) == 0)
                client_key[c] = random_key($urandom_range(50, 72));
            else
                client_key[c] = random_key($urandom_range(1, 16));
        end
        wall_clock = $urandom;
    endtask

    // Mostly repeat visits from the pool under a slowly advancing clock, so
    // windows fill up and get denied; the rest is one-off addresses and odd
    // timestamps.
    task automatic run_traffic(input int unsigned char_budget);
        t_key              key;
        logic [TIME_W-1:0] stamp;
        int unsigned       target;
        int unsigned       r;
        target = chars_queued + char_budget;
        while (chars_queued < target) begin
            if ($urandom_range(99) < 80)
                key = client_key[$urandom_range(CLIENTS - 1)];
            else
                key = random_key($urandom_range(1, 20));
            r = $urandom_range(99);
            if (r < 12)
                wall_clock = wall_clock + 1;
            else if (r < 15)
                wall_clock = wall_clock + $urandom_range(2, 1000);
            stamp = wall_clock;
            if (r >= 95)
                stamp = wall_clock - $urandom_range(1, 5);
            else if (r >= 92)
                stamp = $urandom;
            queue_request(key, stamp);
        end
    endtask

    task automatic wait_for_verdicts();
        do
            @(negedge i_clk);
        while (chars_outstanding != 0 || verdicts_due.size() != 0);
    endtask

    // Quiesce, let any decision still in progress finish, then write the limit.
    task automatic begin_phase(input logic [COUNT_W-1:0] limit,
                               input int unsigned idle_pct, input int unsigned stall_pct);
        wait_for_verdicts();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        rate_limit   = limit;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= COUNT_W'($urandom);
        @(posedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        limit_settings++;
    endtask

    // Character driver: hold a transaction until taken, then pull the next
    // one from the stream unless this cycle idles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || char_taken) begin
            if (char_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_char = char_stream.pop_front();
                req_if.valid       <= 1'b1;
                req_if.key_char    <= next_char.key_char;
                req_if.last_char   <= next_char.last_char;
                req_if.now_seconds <= next_char.now_seconds;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Verdict receiver: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            resp_if.ready <= 1'b0;
        end else if (hold_cycles_left != 0) begin
            resp_if.ready <= 1'b0;
            hold_cycles_left--;
        end else if (hold_off_req) begin
            hold_off_req     = 1'b0;
            hold_cycles_left = HOLD_OFF_CYCLES;
            resp_if.ready <= 1'b0;
        end else begin
            resp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check verdicts first so one issued at this edge never meets
    // an expectation created by a character taken at the same edge.
    always @(posedge i_clk) begin
        char_taken = 1'b0;
        if (i_rst_n) begin
            if (resp_if.valid && resp_if.ready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, got a=%0d n=%0d b=%0d",
                             $time, resp_if.allowed, resp_if.window_count, resp_if.bucket);
                    errors++;
                end else begin
                    automatic t_verdict v = verdicts_due.pop_front();
                    if (resp_if.allowed !== v.allowed || resp_if.window_count !== v.window_count
                        || resp_if.bucket !== v.bucket) begin
                        $display("%0t: mismatch, exp a=%0d n=%0d b=%0d, got a=%0d n=%0d b=%0d",
                                 $time, v.allowed, v.window_count, v.bucket,
                                 resp_if.allowed, resp_if.window_count, resp_if.bucket);
                        errors++;
                    end
                    decisions++;
                    if (v.allowed)
                        admitted++;
                    else
                        denied++;
                end
            end
            if (req_if.valid && req_if.ready) begin
                admit_char('{req_if.key_char, req_if.last_char, req_if.now_seconds});
                chars_outstanding--;
                char_taken = 1'b1;
            end
        end
    end

    // Watchdog: give up when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (resp_if.valid && resp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d verdicts outstanding",
                     $time, WATCHDOG_LIMIT, verdicts_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_key addr_a;
        t_key coll_a;
        t_key coll_b;
        t_key k63;
        t_key k70;
        t_key zero_key;
        t_key top_key;
        t_key bottom_key;
        t_key short_key;

        // Drive every input known from time zero
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        req_if.valid       = 1'b0;
        req_if.key_char    = '0;
        req_if.last_char   = 1'b0;
        req_if.now_seconds = '0;
        resp_if.ready      = 1'b0;

        rate_limit = hfwrl_pkg::LIMIT_RESET;
        djb2_acc   = hfwrl_pkg::HASH_SEED;
        key_len    = 0;
        for (int i = 0; i < KEY_CHARS; i++)
            key_buf[i] = '0;
        for (int b = 0; b < TABLE_ENTRIES; b++) begin
            entry_len[b]   = 0;
            entry_start[b] = '0;
            entry_count[b] = '0;
            for (int i = 0; i < KEY_CHARS; i++)
                entry_key[b][i] = '0;
        end
        chars_outstanding = 0;
        chars_queued      = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_off_req      = 1'b0;
        hold_cycles_left  = 0;
        char_taken        = 1'b0;
        errors            = 0;
        decisions         = 0;
        admitted          = 0;
        denied            = 0;
        limit_settings    = 0;
        quiet_cycles      = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        addr_a     = text_key("192.168.0.17");
        // Same full djb2 hash, different text: forces a bucket collision
        coll_a     = text_key("Aa");
        coll_b     = text_key("B@");
        k63        = random_key(KEY_CHARS);
        k70        = random_key(70);
        zero_key   = '{8'h00, 8'h41};
        top_key    = '{8'hFF};
        bottom_key = '{8'h01};
        short_key  = text_key("zz");

        // Directed: limit of two, written while the table is still clearing
        begin_phase(16'd2, 0, 0);
        queue_request(addr_a, 32'd1000);
        queue_request(addr_a, 32'd1000);
        queue_request(addr_a, 32'd1000);                  // limit reached: deny
        queue_request(addr_a, 32'd999);                   // clock stepped back: same window
        queue_request(addr_a, 32'd1000 + 32'h8000_0000);  // wrapped difference: same window
        queue_request(addr_a, 32'd1001);                  // next second: fresh window
        queue_request(coll_a, 32'd5);
        queue_request(coll_b, 32'd5);                     // collides, replaces entry
        queue_request(coll_a, 32'd5);
        queue_request(k63, 32'd7);
        queue_request(k63, 32'd7);                        // full-length key still matches
        queue_request(k70, 32'd7);
        queue_request(k70, 32'd7);                        // truncated key never matches
        queue_request(zero_key, 32'd9);
        queue_request(zero_key, 32'd9);
        queue_request(top_key, 32'hFFFF_FFFF);
        queue_request(top_key, 32'hFFFF_FFFF);
        queue_request(bottom_key, 32'd0);
        queue_request(bottom_key, 32'd0);

        // Zero limit: matches are denied, replacements still admitted
        begin_phase(16'd0, 0, 0);
        queue_request(addr_a, 32'd1001);
        queue_request(short_key, 32'd1);
        queue_request(short_key, 32'd1);

        // No idling; the receiver holds off long enough to back the block up,
        // and halfway through the sender pauses until everything has drained.
        begin_phase(16'd3, 0, 0);
        new_clients();
        hold_off_req = 1'b1;
        run_traffic(200);
        wait_for_verdicts();
        @(posedge i_clk);
        run_traffic(200);

        begin_phase(16'hFFFF, 82, 0);
        new_clients();
        run_traffic(300);

        begin_phase(16'd1, 0, 82);
        new_clients();
        run_traffic(300);

        begin_phase(COUNT_W'($urandom_range(0, 6)), 21, 21);
        new_clients();
        run_traffic(400);

        begin_phase(hfwrl_pkg::LIMIT_RESET, 0, 0);
        new_clients();
        run_traffic(300);

        // Drain, then give any stray verdict time to show up
        wait_for_verdicts();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Checked %0d admission decisions (%0d admitted, %0d denied) from %0d characters",
                 decisions, admitted, denied, chars_queued);
        $display("over %0d limit settings, with collisions, long keys, stale times and backpressure.",
                 limit_settings);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
